>>> sv/sqc_pkg.sv
package sqc_pkg;

    // Field widths of the command, result and register write items, and of the channel state.
    localparam int CMD_W      = 3;
    localparam int FREQ_W     = 11;
    localparam int STEP_W     = 3;
    localparam int SAMPLE_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int TIMER_W    = 14;
    localparam int LEN_W      = 7;
    localparam int VOL_W      = 4;
    localparam int CNT_W      = 4;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LENGTH   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENVELOPE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRIGGER  = 3'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_SELECT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_INITIAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_INCREASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_SUB     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_SHIFT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ON     = 3'd7;

    // Limits and reload values.
    localparam logic [VOL_W-1:0] VOL_MAX       = 4'd15;
    localparam logic [LEN_W-1:0] LEN_FULL      = 7'd64;
    localparam logic [LEN_W-1:0] LEN_FULL_ODD  = 7'd63;
    localparam logic [CNT_W-1:0] ZERO_RELOAD   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST    = 3'd7;

    // Duty patterns, read from the most significant bit at position zero.
    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] pat;
        case (sel)
            2'd0:    pat = 8'h01;
            2'd1:    pat = 8'h81;
            2'd2:    pat = 8'h87;
            default: pat = 8'h7e;
        endcase
        return pat[3'd7 - pos];
    endfunction

    // Period timer load: (2048 - frequency) * 4.
    function automatic logic [TIMER_W-1:0] period_load(input logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] span;
        span = 12'd2048 - {1'b0, f};
        return {span, 2'b00};
    endfunction

    // Timer reload, where a period of zero counts as eight.
    function automatic logic [CNT_W-1:0] reload_of(input logic [2:0] p);
        return (p == 3'd0) ? ZERO_RELOAD : {1'b0, p};
    endfunction

    // Sweep calculation; bit 11 set means the result is above 2047.
    function automatic logic [FREQ_W:0] sweep_calc(input logic [FREQ_W-1:0] shadow,
                                                   input logic [2:0] shift,
                                                   input logic sub);
        logic [FREQ_W-1:0] delta;
        delta = shadow >> shift;
        return sub ? ({1'b0, shadow} - {1'b0, delta}) : ({1'b0, shadow} + {1'b0, delta});
    endfunction

endpackage

>>> sv/sqc_in_if.sv
interface sqc_in_if;
    logic                        valid;
    logic                        ready;
    logic [sqc_pkg::CMD_W-1:0]   command;
    logic [sqc_pkg::FREQ_W-1:0]  trigger_frequency;
    logic [sqc_pkg::STEP_W-1:0]  sequencer_step;

    modport source (output valid, command, trigger_frequency, sequencer_step,
                    input ready);
    modport sink   (input valid, command, trigger_frequency, sequencer_step,
                    output ready);
endinterface

>>> sv/sqc_out_if.sv
interface sqc_out_if;
    logic                          valid;
    logic                          ready;
    logic [sqc_pkg::SAMPLE_W-1:0]  sample;
    logic                          channel_active;
    logic [sqc_pkg::FREQ_W-1:0]    current_frequency;

    modport source (output valid, sample, channel_active, current_frequency,
                    input ready);
    modport sink   (input valid, sample, channel_active, current_frequency,
                    output ready);
endinterface

>>> sv/sqc_cfg_if.sv
interface sqc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sqc_pkg::CFG_IDX_W-1:0]   index;
    logic [sqc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/square_channel_with_sweep_core.sv
// A result item appears in the cycle after its command item is accepted.
// Throughput: one item per cycle while results drain; the channel state registers are
// updated in the accepting cycle and the result register takes the new state at the same edge.
// Reset (i_rst_n low, synchronous) restores the register defaults and the
// channel state, and empties the result register. Register writes are always taken outside reset.
module square_channel_with_sweep_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sqc_in_if.sink          i_in,
    sqc_cfg_if.sink         i_cfg,
    sqc_out_if.source       o_out
);

    // Configuration registers.
    logic [1:0]                 r_duty_select;
    logic [sqc_pkg::VOL_W-1:0]  r_env_initial;
    logic                       r_env_increase;
    logic [2:0]                 r_env_period;
    logic [2:0]                 r_sweep_pace;
    logic                       r_sweep_sub;
    logic [2:0]                 r_sweep_rshift;
    logic                       r_length_on;

    // Channel state.
    logic                          r_enabled,      n_enabled;
    logic [sqc_pkg::TIMER_W-1:0]   r_period_timer, n_period_timer;
    logic [2:0]                    r_duty_pos,     n_duty_pos;
    logic [sqc_pkg::FREQ_W-1:0]    r_frequency,    n_frequency;
    logic [sqc_pkg::FREQ_W-1:0]    r_shadow,       n_shadow;
    logic                          r_sweep_active, n_sweep_active;
    logic [sqc_pkg::CNT_W-1:0]     r_sweep_timer,  n_sweep_timer;
    logic [sqc_pkg::VOL_W-1:0]     r_volume,       n_volume;
    logic [sqc_pkg::CNT_W-1:0]     r_env_timer,    n_env_timer;
    logic [sqc_pkg::LEN_W-1:0]     r_length_left,  n_length_left;

    // Result register.
    logic                          r_out_valid;
    logic [sqc_pkg::SAMPLE_W-1:0]  r_sample,  n_sample;
    logic                          r_active,  n_active;
    logic [sqc_pkg::FREQ_W-1:0]    r_out_freq;

    logic in_accept;
    logic cfg_accept;

    // The next item is taken whenever the result register is free or drains now.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_accept  = i_cfg.valid;

    assign o_out.valid             = r_out_valid;
    assign o_out.sample            = r_sample;
    assign o_out.channel_active    = r_active;
    assign o_out.current_frequency = r_out_freq;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_select  <= 2'd2;
            r_env_initial  <= 4'd15;
            r_env_increase <= 1'b0;
            r_env_period   <= 3'd3;
            r_sweep_pace   <= 3'd0;
            r_sweep_sub    <= 1'b0;
            r_sweep_rshift <= 3'd0;
            r_length_on    <= 1'b0;
        end else if (cfg_accept) begin
            case (i_cfg.index)
                sqc_pkg::REG_DUTY_SELECT:  r_duty_select  <= i_cfg.data[1:0];
                sqc_pkg::REG_ENV_INITIAL:  r_env_initial  <= i_cfg.data[3:0];
                sqc_pkg::REG_ENV_INCREASE: r_env_increase <= i_cfg.data[0];
                sqc_pkg::REG_ENV_PERIOD:   r_env_period   <= i_cfg.data[2:0];
                sqc_pkg::REG_SWEEP_PERIOD: r_sweep_pace   <= i_cfg.data[2:0];
                sqc_pkg::REG_SWEEP_SUB:    r_sweep_sub    <= i_cfg.data[0];
                sqc_pkg::REG_SWEEP_SHIFT:  r_sweep_rshift <= i_cfg.data[2:0];
                sqc_pkg::REG_LENGTH_ON:    r_length_on    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Next channel state for the command item on the input.
    always_comb begin
        logic [sqc_pkg::TIMER_W-1:0] ptimer;
        logic [sqc_pkg::CNT_W-1:0]   ctimer;
        logic [sqc_pkg::FREQ_W:0]    calc_a;
        logic [sqc_pkg::FREQ_W:0]    calc_b;

        n_enabled      = r_enabled;
        n_period_timer = r_period_timer;
        n_duty_pos     = r_duty_pos;
        n_frequency    = r_frequency;
        n_shadow       = r_shadow;
        n_sweep_active = r_sweep_active;
        n_sweep_timer  = r_sweep_timer;
        n_volume       = r_volume;
        n_env_timer    = r_env_timer;
        n_length_left  = r_length_left;
        ptimer = '0;
        ctimer = '0;
        calc_a = '0;
        calc_b = '0;

        case (i_in.command)
            sqc_pkg::CMD_TICK: begin
                ptimer = (r_period_timer != '0) ? r_period_timer - 1'b1 : r_period_timer;
                n_period_timer = ptimer;
                if (ptimer == '0) begin
                    n_duty_pos     = r_duty_pos + 3'd1;
                    n_period_timer = sqc_pkg::period_load(r_frequency);
                end
            end
            sqc_pkg::CMD_LENGTH: begin
                if (r_length_on && r_length_left != '0) begin
                    n_length_left = r_length_left - 1'b1;
                    if (r_length_left == 7'd1) begin
                        n_enabled = 1'b0;
                    end
                end
            end
            sqc_pkg::CMD_ENVELOPE: begin
                ctimer = (r_env_timer != '0) ? r_env_timer - 1'b1 : r_env_timer;
                n_env_timer = ctimer;
                if (r_env_period != 3'd0 && ctimer == '0) begin
                    if (r_env_increase) begin
                        if (r_volume != sqc_pkg::VOL_MAX) begin
                            n_volume = r_volume + 1'b1;
                        end
                    end else if (r_volume != '0) begin
                        n_volume = r_volume - 1'b1;
                    end
                end
                if (ctimer == '0) begin
                    n_env_timer = sqc_pkg::reload_of(r_env_period);
                end
            end
            sqc_pkg::CMD_SWEEP: begin
                ctimer = (r_sweep_timer != '0) ? r_sweep_timer - 1'b1 : r_sweep_timer;
                n_sweep_timer = ctimer;
                calc_a = sqc_pkg::sweep_calc(r_shadow, r_sweep_rshift, r_sweep_sub);
                calc_b = sqc_pkg::sweep_calc(calc_a[sqc_pkg::FREQ_W-1:0],
                                             r_sweep_rshift, r_sweep_sub);
                if (r_sweep_pace != 3'd0 && r_sweep_active && ctimer == '0) begin
                    if (calc_a[sqc_pkg::FREQ_W]) begin
                        // Overflow of the first calculation silences the channel.
                        n_enabled      = 1'b0;
                        n_sweep_active = 1'b0;
                    end else if (r_sweep_rshift != 3'd0) begin
                        n_shadow    = calc_a[sqc_pkg::FREQ_W-1:0];
                        n_frequency = calc_a[sqc_pkg::FREQ_W-1:0];
                        // The follow-up check only looks for overflow.
                        if (calc_b[sqc_pkg::FREQ_W]) begin
                            n_enabled      = 1'b0;
                            n_sweep_active = 1'b0;
                        end
                    end
                end
                if (ctimer == '0) begin
                    n_sweep_timer = sqc_pkg::reload_of(r_sweep_pace);
                end
            end
            sqc_pkg::CMD_TRIGGER: begin
                n_enabled   = 1'b1;
                n_frequency = i_in.trigger_frequency;
                if (r_length_left == '0) begin
                    n_length_left = (r_length_on && i_in.sequencer_step[0])
                                    ? sqc_pkg::LEN_FULL_ODD : sqc_pkg::LEN_FULL;
                end
                n_period_timer = sqc_pkg::period_load(i_in.trigger_frequency);
                n_volume       = r_env_initial;
                n_env_timer    = sqc_pkg::reload_of(r_env_period)
                                 + {3'd0, i_in.sequencer_step == sqc_pkg::STEP_LAST};
                n_shadow       = i_in.trigger_frequency;
                n_sweep_timer  = sqc_pkg::reload_of(r_sweep_pace);
                n_sweep_active = (r_sweep_pace != 3'd0) || (r_sweep_rshift != 3'd0);
                calc_a = sqc_pkg::sweep_calc(i_in.trigger_frequency, r_sweep_rshift,
                                             r_sweep_sub);
                if (r_sweep_rshift != 3'd0 && calc_a[sqc_pkg::FREQ_W]) begin
                    n_enabled      = 1'b0;
                    n_sweep_active = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Result fields from the state after the command.
    always_comb begin
        n_sample = '0;
        if (n_enabled && sqc_pkg::duty_bit(r_duty_select, n_duty_pos)) begin
            n_sample = n_volume;
        end
        n_active = n_enabled && (r_env_initial != '0 || r_env_increase);
    end

    // State update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b1;
            r_period_timer <= '0;
            r_duty_pos     <= '0;
            r_frequency    <= '0;
            r_shadow       <= '0;
            r_sweep_active <= 1'b0;
            r_sweep_timer  <= '0;
            r_volume       <= '0;
            r_env_timer    <= '0;
            r_length_left  <= '0;
        end else if (in_accept) begin
            r_enabled      <= n_enabled;
            r_period_timer <= n_period_timer;
            r_duty_pos     <= n_duty_pos;
            r_frequency    <= n_frequency;
            r_shadow       <= n_shadow;
            r_sweep_active <= n_sweep_active;
            r_sweep_timer  <= n_sweep_timer;
            r_volume       <= n_volume;
            r_env_timer    <= n_env_timer;
            r_length_left  <= n_length_left;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample   <= n_sample;
            r_active   <= n_active;
            r_out_freq <= n_frequency;
        end
    end

    // A result appears only for an accepted item.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_accept))
        else $error("result item without an accepted command");

    // The frequency moves only on a trigger or a sweep clock.
    a_freq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.command != sqc_pkg::CMD_TRIGGER
                   && i_in.command != sqc_pkg::CMD_SWEEP) |=> $stable(r_frequency))
        else $error("frequency changed by a command that does not set it");

    // A length clock that empties the counter silences the channel.
    a_length_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.command == sqc_pkg::CMD_LENGTH && r_length_on
                   && r_length_left == 7'd1) |=> !r_enabled)
        else $error("channel still enabled after length ran out");

    // The volume does not wrap past its top.
    a_volume_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.command == sqc_pkg::CMD_ENVELOPE && r_env_increase
                   && r_volume == sqc_pkg::VOL_MAX) |=> r_volume == sqc_pkg::VOL_MAX)
        else $error("volume wrapped on increase");

    // An empty result register never holds off the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

endmodule
